// ===== hw/rtl/b2b_pkg.sv =====
package b2b_pkg;

   localparam int ROUND_COUNT  = 12;
   localparam int DIGEST_BYTES = 64;
   localparam int BLOCK_WORDS  = 16;
   localparam int DIGEST_WORDS = DIGEST_BYTES / 8;

   typedef logic [63:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } b2b_state_type;

   localparam logic [3:0] LAST_ROUND = 4'(ROUND_COUNT - 1);

   localparam word_type IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // digest length, fanout 1, depth 1
   localparam word_type PARAM_WORD0 = 64'h0000_0000_0101_0000 | 64'(DIGEST_BYTES & 8'hff);

   localparam logic [3:0] SIGMA [10][16] = '{
      '{ 4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
         4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15 },
      '{ 4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
         4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3 },
      '{ 4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
         4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4 },
      '{ 4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
         4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8 },
      '{ 4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
         4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13 },
      '{ 4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
         4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9 },
      '{ 4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
         4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11 },
      '{ 4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
         4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10 },
      '{ 4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
         4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5 },
      '{ 4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
         4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0 }
   };

   function automatic logic [3:0] sigma_lookup(logic [3:0] rnd, logic [3:0] idx);
      logic [3:0] row;
      row = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
      return SIGMA[row][idx];
   endfunction

   // row rotation after the last step of a mix: skew before the diagonals, unskew after
   function automatic logic [1:0] shift_amount(logic [2:0] mix_idx, logic [1:0] row);
      logic [1:0] amt;
      if (mix_idx == 3'd3) begin
         amt = 2'd1 + row;
      end else if (mix_idx == 3'd7) begin
         amt = 2'd1 - row;
      end else begin
         amt = 2'd1;
      end
      return amt;
   endfunction

   function automatic logic [1:0] rot_index(logic [1:0] pos, logic [1:0] amt);
      return pos + amt;
   endfunction

endpackage

// ===== hw/rtl/b2b_mix.sv =====
module b2b_mix
   import b2b_pkg::*;
(
   input  logic [1:0] phase,
   input  word_type   a_word,
   input  word_type   b_word,
   input  word_type   c_word,
   input  word_type   d_word,
   input  word_type   msg_word,
   output word_type   a_next,
   output word_type   b_next,
   output word_type   c_next,
   output word_type   d_next
);

   word_type op0;
   word_type op1;
   word_type op2;
   word_type sum;
   word_type dx;
   word_type bx;

   always_comb begin
      op0 = phase[0] ? c_word : a_word;
      op1 = phase[0] ? d_word : b_word;
      op2 = phase[0] ? '0 : msg_word;
      sum = op0 + op1 + op2;
      dx  = d_word ^ sum;
      bx  = b_word ^ sum;
      a_next = a_word;
      b_next = b_word;
      c_next = c_word;
      d_next = d_word;
      unique case (phase)
         2'd0: begin
            a_next = sum;
            d_next = {dx[31:0], dx[63:32]};
         end
         2'd1: begin
            c_next = sum;
            b_next = {bx[23:0], bx[63:24]};
         end
         2'd2: begin
            a_next = sum;
            d_next = {dx[15:0], dx[63:16]};
         end
         2'd3: begin
            c_next = sum;
            b_next = {bx[62:0], bx[63]};
         end
         default: begin
            a_next = a_word;
         end
      endcase
   end

endmodule

// ===== hw/rtl/blake2b_hash_engine.sv =====
// Unkeyed BLAKE2b-512 over a stream of little-endian 64-bit message words. A word
// that does not complete a block is stored, and the engine stays ready for the next. The
// sixteenth word of a block, and the word marked last, start a compression: a load
// state, the shared mixing unit (12 rounds of 8 mixes, each mix 4 add/xor/rotate
// steps through one three-operand 64-bit adder), and a fold of the work vector
// into the chain value, during all of which req_tready is low. After the last word
// the eight digest words follow on rsp, lowest word first, with rsp_tlast on the
// eighth, and the engine is then ready for a new message. An empty message is a
// single last word with zero valid bytes.
module blake2b_hash_engine
   import b2b_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // message_word[63:0], valid_bytes[67:64], zero fill
   input  logic        req_tlast,  // last_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // digest_word[63:0]
   output logic        rsp_tlast   // digest_last
);

   b2b_state_type state_ff, state_in;
   logic [3:0]    pos_ff, pos_in;
   logic [1:0]    phase_ff, phase_in;
   logic [2:0]    mix_ff, mix_in;
   logic [3:0]    round_ff, round_in;
   logic [2:0]    out_ff, out_in;
   logic          final_ff, final_in;
   word_type      cnt_lo_ff, cnt_lo_in;
   word_type      cnt_hi_ff, cnt_hi_in;
   word_type      h_ff [8];
   word_type      h_in [8];
   word_type      blk_ff [BLOCK_WORDS];
   word_type      blk_in [BLOCK_WORDS];
   word_type      v_ff [4][4];
   word_type      v_in [4][4];
   word_type      upd [4][4];

   word_type      in_word;
   logic [3:0]    in_valid;
   logic [3:0]    vcap;
   word_type      masked;
   logic [7:0]    add_amt;
   logic [64:0]   cnt_sum;
   word_type      msg_word;
   word_type      a_next;
   word_type      b_next;
   word_type      c_next;
   word_type      d_next;

   assign in_word  = req_tdata[63:0];
   assign in_valid = req_tdata[67:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = h_ff[out_ff];
   assign rsp_tlast  = (out_ff == 3'(DIGEST_WORDS - 1));

   assign msg_word = blk_ff[sigma_lookup(round_ff, {mix_ff, phase_ff[1]})];

   b2b_mix u_mix (
      .phase    (phase_ff),
      .a_word   (v_ff[0][0]),
      .b_word   (v_ff[1][0]),
      .c_word   (v_ff[2][0]),
      .d_word   (v_ff[3][0]),
      .msg_word (msg_word),
      .a_next   (a_next),
      .b_next   (b_next),
      .c_next   (c_next),
      .d_next   (d_next)
   );

   always_comb begin
      vcap = (in_valid > 4'd8) ? 4'd8 : in_valid;
      for (int b = 0; b < 8; b++) begin
         masked[8*b +: 8] = (4'(b) < vcap) ? in_word[8*b +: 8] : 8'h00;
      end
      if (req_tlast) begin
         add_amt = {1'b0, pos_ff, 3'b000} + {4'b0000, vcap};
      end else begin
         add_amt = (pos_ff == 4'(BLOCK_WORDS - 1)) ? 8'd128 : 8'd0;
      end
      cnt_sum = {1'b0, cnt_lo_ff} + {57'd0, add_amt};
   end

   always_comb begin
      upd = v_ff;
      upd[0][0] = a_next;
      upd[1][0] = b_next;
      upd[2][0] = c_next;
      upd[3][0] = d_next;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      mix_in    = mix_ff;
      round_in  = round_ff;
      out_in    = out_ff;
      final_in  = final_ff;
      cnt_lo_in = cnt_lo_ff;
      cnt_hi_in = cnt_hi_ff;
      h_in      = h_ff;
      blk_in    = blk_ff;
      v_in      = v_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  blk_in[pos_ff] = masked;
                  for (int i = 0; i < BLOCK_WORDS; i++) begin
                     if (4'(i) > pos_ff) begin
                        blk_in[i] = '0;
                     end
                  end
                  cnt_lo_in = cnt_sum[63:0];
                  cnt_hi_in = cnt_hi_ff + 64'(cnt_sum[64]);
                  final_in  = 1'b1;
                  pos_in    = '0;
                  state_in  = ST_LOAD;
               end else begin
                  blk_in[pos_ff] = in_word;
                  pos_in = pos_ff + 4'd1;
                  if (pos_ff == 4'(BLOCK_WORDS - 1)) begin
                     cnt_lo_in = cnt_sum[63:0];
                     cnt_hi_in = cnt_hi_ff + 64'(cnt_sum[64]);
                     final_in  = 1'b0;
                     state_in  = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            for (int j = 0; j < 4; j++) begin
               v_in[0][j] = h_ff[j];
               v_in[1][j] = h_ff[j + 4];
               v_in[2][j] = IV[j];
            end
            v_in[3][0] = IV[4] ^ cnt_lo_ff;
            v_in[3][1] = IV[5] ^ cnt_hi_ff;
            v_in[3][2] = IV[6] ^ {64{final_ff}};
            v_in[3][3] = IV[7];
            phase_in = '0;
            mix_in   = '0;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (phase_ff != 2'd3) begin
               v_in = upd;
            end else begin
               for (int r = 0; r < 4; r++) begin
                  for (int j = 0; j < 4; j++) begin
                     v_in[r][j] = upd[r][rot_index(2'(j), shift_amount(mix_ff, 2'(r)))];
                  end
               end
            end
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               mix_in = mix_ff + 3'd1;
               if (mix_ff == 3'd7) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == LAST_ROUND) begin
                     state_in = ST_FOLD;
                  end
               end
            end
         end
         ST_FOLD: begin
            for (int j = 0; j < 4; j++) begin
               h_in[j]     = h_ff[j] ^ v_ff[0][j] ^ v_ff[2][j];
               h_in[j + 4] = h_ff[j + 4] ^ v_ff[1][j] ^ v_ff[3][j];
            end
            out_in   = '0;
            state_in = final_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'(DIGEST_WORDS - 1)) begin
                  for (int i = 0; i < 8; i++) begin
                     h_in[i] = IV[i];
                  end
                  h_in[0]   = IV[0] ^ PARAM_WORD0;
                  cnt_lo_in = '0;
                  cnt_hi_in = '0;
                  pos_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         phase_ff  <= '0;
         mix_ff    <= '0;
         round_ff  <= '0;
         out_ff    <= '0;
         final_ff  <= 1'b0;
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= (i == 0) ? (IV[0] ^ PARAM_WORD0) : IV[i];
         end
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         mix_ff    <= mix_in;
         round_ff  <= round_in;
         out_ff    <= out_in;
         final_ff  <= final_in;
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         h_ff      <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
   end

endmodule
